>>> hw/rtl/minifloat_to_binary32_decoder_defines.svh
// Assertion macros shared by the minifloat to binary32 decoder RTL.
`ifndef MINIFLOAT_TO_BINARY32_DECODER_DEFINES_SVH
`define MINIFLOAT_TO_BINARY32_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define M2B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define M2B_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define M2B_ASSERT(lbl, prop, msg)
`define M2B_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/m2b_pkg.sv
// Shared types and constants of the minifloat to binary32 decoder.
`timescale 1ns / 1ps
`default_nettype none
package m2b_pkg;

  localparam int MagW = 63;
  localparam int SclW = 18;
  localparam int NumStages = 5;

  localparam logic [6:0] TotalWReset = 7'd32;
  localparam logic [4:0] ExpWReset   = 5'd8;
  localparam logic [5:0] FracWReset  = 6'd23;

  typedef enum logic [1:0] {
    RegTotalW = 2'd0,
    RegExpW   = 2'd1,
    RegFracW  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [6:0] total_width;
    logic [4:0] exp_width;
    logic [5:0] frac_width;
  } fmt_t;

  typedef struct packed {
    logic                   sign;
    logic [MagW-1:0]        mag;
    logic signed [SclW-1:0] scale;
  } unp_t;

  typedef struct packed {
    logic                   sign;
    logic [MagW-1:0]        mag;
    logic signed [SclW-1:0] scale;
    logic [5:0]             msb;
  } lz_t;

  typedef struct packed {
    logic                   sign;
    logic [MagW-1:0]        mag;
    logic signed [SclW-1:0] lsb;
    logic signed [SclW-1:0] rsh;
  } norm_t;

  typedef struct packed {
    logic                   sign;
    logic                   zero;
    logic [23:0]            q;
    logic                   guard;
    logic                   sticky;
    logic signed [SclW-1:0] lsb;
  } shf_t;

endpackage
`default_nettype wire

>>> hw/rtl/m2b_unpack.sv
// First stage: clamps the format, splits the pattern and forms magnitude and scale.
`timescale 1ns / 1ps
`default_nettype none
module m2b_unpack (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire m2b_pkg::fmt_t fmt_i,
  input  wire logic [63:0]  pattern_i,
  output m2b_pkg::unp_t     unp_o
);
  import m2b_pkg::*;

  logic [6:0]  tw;
  logic [4:0]  ew;
  logic [5:0]  fw;
  logic [6:0]  tw_m1;
  logic [63:0] pat_m;
  logic [63:0] sh;
  logic [16:0] emask;
  logic [15:0] e;
  logic [62:0] fmask;
  logic [62:0] f;
  logic [62:0] hid;
  logic [15:0] bias;
  logic signed [SclW-1:0] ex;
  unp_t unp_d, unp_q;

  always_comb begin
    tw = fmt_i.total_width;
    if (tw < 7'd2) tw = 7'd2;
    else if (tw > 7'd64) tw = 7'd64;
    ew = fmt_i.exp_width;
    if (ew < 5'd1) ew = 5'd1;
    else if (ew > 5'd16) ew = 5'd16;
    fw = fmt_i.frac_width;
    if (fw < 6'd1) fw = 6'd1;
    else if (fw > 6'd62) fw = 6'd62;
    for (int i = 0; i < 64; i++) begin
      pat_m[i] = pattern_i[i] & (7'(i) < tw);
    end
    tw_m1 = tw - 7'd1;
    sh    = pat_m >> fw;
    emask = (17'd1 << ew) - 17'd1;
    e     = sh[15:0] & emask[15:0];
    fmask = (63'd1 << fw) - 63'd1;
    f     = pat_m[62:0] & fmask;
    hid   = 63'd1 << fw;
    bias  = (16'd1 << (ew - 5'd1)) - 16'd1;
    if (e == 16'd0) begin
      unp_d.mag = f;
      ex = 18'sd1 - $signed({2'b00, bias});
    end else begin
      unp_d.mag = f | hid;
      ex = $signed({2'b00, e}) - $signed({2'b00, bias});
    end
    unp_d.sign  = pat_m[tw_m1[5:0]];
    unp_d.scale = ex - $signed({12'd0, fw});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unp_q <= unp_d;
    end
  end

  assign unp_o = unp_q;

endmodule
`default_nettype wire

>>> hw/rtl/m2b_lzc.sv
// Second and third stages: finds the leading one and places the result grid.
`timescale 1ns / 1ps
`default_nettype none
module m2b_lzc (
  input  wire logic          clk_i,
  input  wire logic [1:0]    en_i,
  input  wire m2b_pkg::unp_t unp_i,
  output m2b_pkg::norm_t     norm_o
);
  import m2b_pkg::*;

  lz_t   lz_d, lz_q;
  norm_t norm_d, norm_q;
  logic signed [SclW-1:0] lsb;

  always_comb begin
    lz_d.sign  = unp_i.sign;
    lz_d.mag   = unp_i.mag;
    lz_d.scale = unp_i.scale;
    lz_d.msb   = 6'd0;
    for (int i = 0; i < MagW; i++) begin
      if (unp_i.mag[i]) lz_d.msb = 6'(i);
    end
  end

  always_comb begin
    lsb = $signed({12'd0, lz_q.msb}) + lz_q.scale - 18'sd23;
    if (lsb < -18'sd149) lsb = -18'sd149;
    norm_d.sign = lz_q.sign;
    norm_d.mag  = lz_q.mag;
    norm_d.lsb  = lsb;
    norm_d.rsh  = lsb - lz_q.scale;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lz_q <= lz_d;
    end
    if (en_i[1]) begin
      norm_q <= norm_d;
    end
  end

  assign norm_o = norm_q;

endmodule
`default_nettype wire

>>> hw/rtl/m2b_round.sv
// Fourth and fifth stages: aligns the magnitude, rounds to nearest even and packs binary32.
`timescale 1ns / 1ps
`default_nettype none
module m2b_round (
  input  wire logic           clk_i,
  input  wire logic [1:0]     en_i,
  input  wire m2b_pkg::norm_t norm_i,
  output logic [31:0]         value_bits_o
);
  import m2b_pkg::*;

  shf_t         shf_d, shf_q;
  logic [4:0]   negr;
  logic [6:0]   sh7;
  logic [125:0] wide;
  logic [62:0]  lsh;
  logic [SclW-1:0] nr;
  logic         up;
  logic [24:0]  q25;
  logic [23:0]  qf;
  logic signed [SclW-1:0] lsbf;
  logic [SclW-1:0] bexp;
  logic [31:0]  res;
  logic [31:0]  value_d, value_q;

  always_comb begin
    nr   = SclW'(-norm_i.rsh);
    negr = nr[4:0];
    lsh  = norm_i.mag << negr;
    sh7  = (norm_i.rsh >= 18'sd64) ? 7'd64 : norm_i.rsh[6:0];
    wide = {norm_i.mag, 63'd0} >> sh7;
    shf_d.sign = norm_i.sign;
    shf_d.zero = (norm_i.mag == '0);
    shf_d.lsb  = norm_i.lsb;
    if (norm_i.rsh <= 18'sd0) begin
      shf_d.q      = lsh[23:0];
      shf_d.guard  = 1'b0;
      shf_d.sticky = 1'b0;
    end else begin
      shf_d.q      = wide[86:63];
      shf_d.guard  = wide[62];
      shf_d.sticky = |wide[61:0];
    end
  end

  always_comb begin
    up   = shf_q.guard & (shf_q.sticky | shf_q.q[0]);
    q25  = {1'b0, shf_q.q} + {24'd0, up};
    lsbf = shf_q.lsb;
    qf   = q25[23:0];
    if (q25[24]) begin
      qf   = q25[24:1];
      lsbf = shf_q.lsb + 18'sd1;
    end
    bexp = SclW'(lsbf + 18'sd149);
    if (shf_q.zero || qf == 24'd0) begin
      res = 32'd0;
    end else if (qf[23] && lsbf >= 18'sd105) begin
      res = 32'h7F80_0000;
    end else begin
      res = {bexp[8:0], 23'd0} + {8'd0, qf};
    end
    value_d = {shf_q.sign, res[30:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      shf_q <= shf_d;
    end
    if (en_i[1]) begin
      value_q <= value_d;
    end
  end

  assign value_bits_o = value_q;

endmodule
`default_nettype wire

>>> hw/rtl/minifloat_to_binary32_decoder.sv
// Top level of the minifloat to binary32 decoder: register port, pipeline control, stages.
//
//   channel  direction  handshake        payload
//   input    in         valid_i/stall_o  pattern_i (64 bits)
//   output   out        valid_o/stall_i  value_bits_o (32 bits)
//   config   in         APB write/read   total_width, exp_width, frac_width
//
// Each word passes five register stages before it leaves.
// One word is accepted every cycle while the output side does not stall.
// A stall holds only the stages that are full, so bubbles are squeezed out.
// Reset clears the valid bits and loads the format registers with 32, 8 and 23.
`timescale 1ns / 1ps
`default_nettype none
`include "minifloat_to_binary32_decoder_defines.svh"
module minifloat_to_binary32_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [63:0] pattern_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      value_bits_o
);
  import m2b_pkg::*;

  fmt_t fmt_q;
  logic [NumStages-1:0] v_q, v_d, en;
  unp_t  unp;
  norm_t norm;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q.total_width <= TotalWReset;
      fmt_q.exp_width   <= ExpWReset;
      fmt_q.frac_width  <= FracWReset;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegTotalW: fmt_q.total_width <= pwdata[6:0];
        RegExpW:   fmt_q.exp_width   <= pwdata[4:0];
        RegFracW:  fmt_q.frac_width  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegTotalW: prdata = {25'd0, fmt_q.total_width};
      RegExpW:   prdata = {27'd0, fmt_q.exp_width};
      RegFracW:  prdata = {26'd0, fmt_q.frac_width};
      default:   prdata = 32'd0;
    endcase
  end

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = valid_i;
    for (int k = 1; k < NumStages; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NumStages-1];

  m2b_unpack u_unpack (
    .clk_i     (clk_i),
    .en_i      (en[0]),
    .fmt_i     (fmt_q),
    .pattern_i (pattern_i),
    .unp_o     (unp)
  );

  m2b_lzc u_lzc (
    .clk_i  (clk_i),
    .en_i   (en[2:1]),
    .unp_i  (unp),
    .norm_o (norm)
  );

  m2b_round u_round (
    .clk_i        (clk_i),
    .en_i         (en[4:3]),
    .norm_i       (norm),
    .value_bits_o (value_bits_o)
  );

  `M2B_ASSERT(a_stall_cause, stall_o |-> (valid_o && stall_i), "input stalled without a held word")
  `M2B_ASSERT(a_no_nan, (valid_o && value_bits_o[30:23] == 8'hFF) |-> (value_bits_o[22:0] == 23'd0), "decoded word is a NaN")
  `M2B_ASSERT(a_accept_moves, (valid_i && !stall_o) |=> v_q[0], "accepted word did not enter the pipeline")
  `M2B_ASSERT_RST(a_reset_empty, !rst_ni |-> !valid_o, "output valid during reset")

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the minifloat to binary32 decoder with a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import m2b_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [63:0] pattern_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] value_bits_o;

  logic [6:0]  fmt_total = TotalWReset;
  logic [4:0]  fmt_exp = ExpWReset;
  logic [5:0]  fmt_frac = FracWReset;
  logic [31:0] expected_bits[$];
  int          errors = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          done = 1'b0;

  minifloat_to_binary32_decoder u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] round_binary32(logic [63:0] mag, int scale);
    int msb, lsb, r;
    logic [63:0] q, rem, half;
    msb = 63;
    while (msb > 0 && !mag[msb]) msb--;
    lsb = msb + scale - 23;
    if (lsb < -149) lsb = -149;
    r = lsb - scale;
    if (r <= 0) begin
      q = mag << (-r);
    end else if (r >= 64) begin
      q = '0;
    end else begin
      rem = mag & ((64'd1 << r) - 64'd1);
      half = 64'd1 << (r - 1);
      q = mag >> r;
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (q == (64'd1 << 24)) begin
      q = q >> 1;
      lsb++;
    end
    if (q == 0) return 32'd0;
    if (q >= (64'd1 << 23) && lsb + 150 >= 255) return 32'h7F80_0000;
    return ((lsb + 149) << 23) + q[31:0];
  endfunction

  function automatic logic [31:0] decode_pattern(logic [63:0] raw);
    int tw, ew, fw, bias, ex;
    logic [63:0] pat, e, f, mag;
    logic sign;
    logic [31:0] bits;
    tw = fmt_total < 2 ? 2 : (fmt_total > 64 ? 64 : fmt_total);
    ew = fmt_exp < 1 ? 1 : (fmt_exp > 16 ? 16 : fmt_exp);
    fw = fmt_frac < 1 ? 1 : (fmt_frac > 62 ? 62 : fmt_frac);
    pat = raw;
    if (tw < 64) pat &= (64'd1 << tw) - 64'd1;
    sign = pat[tw-1];
    e = fw >= 64 ? 64'd0 : ((pat >> fw) & ((64'd1 << ew) - 64'd1));
    f = pat & ((64'd1 << fw) - 64'd1);
    bias = (1 << (ew - 1)) - 1;
    if (e == 0) begin
      mag = f;
      ex = 1 - bias;
    end else begin
      mag = f | (64'd1 << fw);
      ex = int'(e) - bias;
    end
    bits = (mag == 0) ? 32'd0 : round_binary32(mag, ex - fw);
    bits[31] = bits[31] | sign;
    return bits;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) expected_bits.push_back(decode_pattern(pattern_i));
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_bits.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h", $time, value_bits_o);
      end else begin
        want = expected_bits.pop_front();
        if (want !== value_bits_o) begin
          errors++;
          $display("%0t: value_bits expected %h actual %h", $time, want, value_bits_o);
        end
      end
    end
  end

  // The receiver stalls at random, or continuously during a hold-off.
  initial begin
    int gap;
    while (!done) begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        stall_i <= 1'b1;
        hold_off--;
      end else if (stall_i) begin
        stall_i <= 1'b0;
      end else begin
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
          stall_i <= 1'b1;
          repeat (gap - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegTotalW: fmt_total = data[6:0];
      RegExpW:   fmt_exp = data[4:0];
      default:   fmt_frac = data[5:0];
    endcase
  endtask

  task automatic send_word(logic [63:0] pat, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    pattern_i <= pat;
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_format(int tw, int ew, int fw);
    write_reg(RegTotalW, tw);
    write_reg(RegExpW, ew);
    write_reg(RegFracW, fw);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    logic [63:0] pats[$];
    pats = '{64'd0, 64'h8000_0000, 64'h7F80_0000, 64'hFF7F_FFFF, 64'h0000_0001,
             64'h807F_FFFF, 64'h3F80_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678_0000_0000};
    foreach (pats[i]) send_word(pats[i], 1'b0);
    drain();
    set_format(64, 16, 47);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h8000_0000_0000_0001, 1'b0);
    send_word(64'h3FFF_8000_0000_0000, 1'b0);
    drain();
    set_format(2, 1, 1);
    for (int i = 0; i < 4; i++) send_word(64'(i), 1'b0);
    drain();
    set_format(0, 0, 0);
    send_word(64'h3, 1'b0);
    drain();
    set_format(127, 31, 63);
    for (int i = 0; i < 4; i++) send_word(random_word(), 1'b0);
    drain();
  endtask

  task automatic test_random_formats();
    for (int p = 0; p < 20; p++) begin
      if (p % 5 == 0) set_format($urandom_range(0, 127), $urandom_range(0, 31),
                                 $urandom_range(0, 63));
      else set_format($urandom_range(2, 64), $urandom_range(1, 16), $urandom_range(1, 62));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 7) == 0) send_word(64'(1) << $urandom_range(0, 63), 1'b0);
        else send_word(random_word(), 1'b0);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_format(16, 5, 10);
    hold_off = 60;
    for (int i = 0; i < 30; i++) send_word(random_word(), 1'b1);
    drain();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_formats();
    test_backpressure();
    done = 1'b1;
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/m2b_pkg.sv
hw/rtl/m2b_unpack.sv
hw/rtl/m2b_lzc.sv
hw/rtl/m2b_round.sv
hw/rtl/minifloat_to_binary32_decoder.sv
verif/tb.sv
